>>> hdl/lkf_pkg.sv
// ----------------------------------------------------------------------------
// lkf_pkg
// Types and constants shared by the longest-ones-with-flips block.
// ----------------------------------------------------------------------------
`default_nettype none

package lkf_pkg;

    localparam int K_MAX      = 255;
    localparam int RING_DEPTH = K_MAX + 1;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int LIMIT_W    = 8;
    localparam int POS_W      = 16;
    localparam int LEN_W      = 16;
    localparam int MAX_LEN    = 65535;

    typedef struct packed {
        logic bit_value;
        logic is_last;
    } item_t;

    typedef struct packed {
        logic [LEN_W-1:0] window_len;
        logic [LEN_W-1:0] best_len;
        logic             done_res;
        logic             overflow;
    } result_t;

    // Write and read requests from the window logic to the zero ring.
    typedef struct packed {
        logic               wr_en;
        logic [RING_AW-1:0] wr_addr;
        logic [POS_W-1:0]   wr_data;
        logic [RING_AW-1:0] rd_addr;
    } ring_req_t;

endpackage

`default_nettype wire

>>> hdl/lkf_ram.sv
// ----------------------------------------------------------------------------
// lkf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module lkf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> hdl/lkf_window.sv
// ----------------------------------------------------------------------------
// lkf_window
// Sliding-window state: zero ring control, left edge, best length and the
// computation of one result per accepted bit.
// ----------------------------------------------------------------------------
`default_nettype none

module lkf_window (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [lkf_pkg::LIMIT_W-1:0] cfg_data,
    input  wire logic                        accept,
    input  wire lkf_pkg::item_t              item,
    output lkf_pkg::result_t                 result
);

    logic [lkf_pkg::LIMIT_W-1:0] limit_reg;
    logic [lkf_pkg::CNT_W-1:0]   count_reg, count_next, count_push;
    logic [lkf_pkg::RING_AW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [lkf_pkg::POS_W-1:0]   position_reg, position_next;
    logic [lkf_pkg::POS_W-1:0]   left_reg, left_next;
    logic [lkf_pkg::LEN_W-1:0]   best_reg, best_next;
    logic                        ovf_reg, ovf_next;
    logic                        bypass_reg;
    logic [lkf_pkg::POS_W-1:0]   bypass_data_reg;

    logic [lkf_pkg::POS_W-1:0]   idx, idx_p1, popped, popped_p1, head_data, rd_data;
    logic [lkf_pkg::LEN_W-1:0]   win;
    logic                        push, pop, sat;
    lkf_pkg::ring_req_t          req;

    lkf_ram #(
        .WIDTH (lkf_pkg::POS_W),
        .DEPTH (lkf_pkg::RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr),
        .wr_data (req.wr_data),
        .rd_addr (req.rd_addr),
        .rd_data (rd_data)
    );

    // The RAM always reads the entry at the head that the next item will see.
    // A write to that same entry in this cycle is forwarded around the RAM.
    assign head_data = bypass_reg ? bypass_data_reg : rd_data;

    always_comb
    begin
        sat = (position_reg >= lkf_pkg::POS_W'(lkf_pkg::MAX_LEN));
        idx = sat ? lkf_pkg::POS_W'(lkf_pkg::MAX_LEN - 1) : position_reg;
        position_next = position_reg;
        ovf_next = ovf_reg;
        if (accept)
        begin
            if (sat)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                position_next = position_reg + 1'b1;
            end
        end

        push = accept && !item.bit_value &&
               (count_reg < lkf_pkg::CNT_W'(lkf_pkg::RING_DEPTH));
        count_push = count_reg + lkf_pkg::CNT_W'(push);

        // Limit never exceeds K_MAX since the register is 8 bits wide.
        pop = accept && (count_push > lkf_pkg::CNT_W'(limit_reg)) &&
              (count_push != '0);
        // With an empty ring the popped zero is the one pushed just now.
        popped = (count_reg == '0) ? idx : head_data;
        popped_p1 = popped + 1'b1;

        left_next = left_reg;
        if (pop && (popped_p1 > left_reg))
        begin
            left_next = popped_p1;
        end

        idx_p1 = idx + 1'b1;
        win = (idx_p1 >= left_next) ? lkf_pkg::LEN_W'(idx_p1 - left_next) : '0;
        best_next = best_reg;
        if (accept && (win > best_reg))
        begin
            best_next = win;
        end

        count_next = count_push - lkf_pkg::CNT_W'(pop);
        tail_next = tail_reg + lkf_pkg::RING_AW'(push);
        head_next = head_reg + lkf_pkg::RING_AW'(pop);

        result.window_len = win;
        result.best_len = best_next;
        result.done_res = item.is_last;
        result.overflow = ovf_next;

        if (accept && item.is_last)
        begin
            count_next = '0;
            tail_next = '0;
            head_next = '0;
            position_next = '0;
            left_next = '0;
            best_next = '0;
            ovf_next = 1'b0;
        end

        req.wr_en = push;
        req.wr_addr = tail_reg;
        req.wr_data = idx;
        req.rd_addr = head_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
            count_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            position_reg <= '0;
            left_reg <= '0;
            best_reg <= '0;
            ovf_reg <= 1'b0;
            bypass_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            count_reg <= count_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            position_reg <= position_next;
            left_reg <= left_next;
            best_reg <= best_next;
            ovf_reg <= ovf_next;
            bypass_reg <= req.wr_en && (req.wr_addr == req.rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        bypass_data_reg <= req.wr_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= lkf_pkg::CNT_W'(lkf_pkg::RING_DEPTH))
        else $error("zero count exceeds ring depth");

    a_left_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
        left_reg <= position_reg)
        else $error("left edge passed the element index");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.is_last |=>
            (position_reg == '0) && (count_reg == '0) && (best_reg == '0) && !ovf_reg)
        else $error("sequence state not cleared after last transfer");

    // The pointer difference wraps at the ring size.
    a_ring_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != lkf_pkg::CNT_W'(lkf_pkg::RING_DEPTH)) |->
            (lkf_pkg::RING_AW'(tail_reg - head_reg) ==
             count_reg[lkf_pkg::RING_AW-1:0]))
        else $error("ring pointers disagree with zero count");

endmodule

`default_nettype wire

>>> hdl/longest_ones_with_k_flips.sv
// ----------------------------------------------------------------------------
// longest_ones_with_k_flips
// Longest run of ones in a bit stream when up to flip_limit zeros may count
// as ones; one result per input bit.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (item_valid, item_stall, item) carries one bit of the
//   sequence per transfer, with is_last marking the final bit. The result
//   channel (res_valid, res_stall, res) returns one result per input bit:
//   the window length ending at that bit, the best length so far, the done
//   flag copied from is_last and a sticky overflow flag.
//   Throughput is one bit per cycle while res_stall is low; the zero ring is a
//   RAM whose head entry is prefetched, so a push and a pop happen in the same
//   cycle. When res_stall is high the result is held and one more input is
//   taken into a skid register; only then does item_stall rise. The user must
//   write flip_limit through cfg_we/cfg_data while the block is idle; the
//   block does not enforce this. Reset clears flip_limit, the sequence state
//   and both result valid flags. After a transfer with is_last set, sequence
//   state clears and flip_limit is kept. Positions saturate at 65534 and set
//   the overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_ones_with_k_flips (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [lkf_pkg::LIMIT_W-1:0] cfg_data,
    input  wire logic                        item_valid,
    output logic                             item_stall,
    input  wire lkf_pkg::item_t              item,
    output logic                             res_valid,
    input  wire logic                        res_stall,
    output lkf_pkg::result_t                 res
);

    logic             out_valid_reg, skid_valid_reg;
    lkf_pkg::result_t out_reg, skid_reg, result;
    logic             accept, out_fire;

    assign item_stall = skid_valid_reg;
    assign accept = item_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !res_stall;
    assign res_valid = out_valid_reg;
    assign res = out_reg;

    lkf_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .accept   (accept),
        .item     (item),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output is empty");

    a_win_le_best: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.window_len <= res.best_len))
        else $error("window length above best length");

    a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_valid)
        else $error("accepted transfer produced no result");

endmodule

`default_nettype wire

>>> tb/longest_ones_with_k_flips_test.sv
// ----------------------------------------------------------------------------
// longest_ones_with_k_flips_test
// Self-checking bench for the longest-ones-with-flips block. A short table of
// directed bits is walked first, then a back-to-back sequence under long
// receiver hold-offs, then random sequences under changing flip limits. Every
// result transfer is compared field by field with a window predictor or typed row.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_ones_with_k_flips_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_ITEMS = 700;
    localparam int          LONG_HOLD    = 80;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int unsigned LEN_CAP      = 2 ** lkf_pkg::LEN_W - 1;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                   kind;
        logic [lkf_pkg::LIMIT_W-1:0] limit;
        logic                        bit_value;
        logic                        is_last;
        bit                          typed;
        lkf_pkg::result_t            want;
    } dir_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [lkf_pkg::LIMIT_W-1:0] cfg_data;
    logic                        item_valid;
    logic                        item_stall;
    lkf_pkg::item_t              item;
    logic                        res_valid;
    logic                        res_stall;
    lkf_pkg::result_t            res;

    // Window predictor state.
    int unsigned                 zero_pos [lkf_pkg::RING_DEPTH];
    int unsigned                 zero_cnt;
    int unsigned                 zero_head;
    int unsigned                 zero_tail;
    int unsigned                 seq_pos;
    int unsigned                 win_left;
    int unsigned                 best_run;
    bit                          seq_ovf;
    logic [lkf_pkg::LIMIT_W-1:0] limit_q;

    lkf_pkg::result_t            expected_results [$];
    dir_row_t                    dir_rows [$];
    int                          err_count;
    int                          results_seen;
    int                          items_sent;
    bit                          tx_idle;
    bit                          rx_idle;
    int                          long_holds;

    longest_ones_with_k_flips u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

    always #5 clk = ~clk;

    function automatic void clear_window();
        zero_cnt  = 0;
        zero_head = 0;
        zero_tail = 0;
        seq_pos   = 0;
        win_left  = 0;
        best_run  = 0;
        seq_ovf   = 1'b0;
    endfunction

    function automatic lkf_pkg::result_t advance_window(logic b, logic last);
        int unsigned      idx;
        int unsigned      popped;
        int unsigned      lim;
        int unsigned      win;
        lkf_pkg::result_t r;
        lim = (limit_q > lkf_pkg::K_MAX) ? lkf_pkg::K_MAX : limit_q;
        // Past the end of the position range the index sticks one below it.
        if (seq_pos >= lkf_pkg::MAX_LEN)
        begin
            seq_ovf = 1'b1;
            idx = lkf_pkg::MAX_LEN - 1;
        end
        else
        begin
            idx = seq_pos;
            seq_pos++;
        end
        if (!b && zero_cnt < lkf_pkg::RING_DEPTH)
        begin
            zero_pos[zero_tail] = idx;
            zero_tail = (zero_tail + 1) % lkf_pkg::RING_DEPTH;
            zero_cnt++;
        end
        // Only one zero leaves per bit, so a lowered limit shrinks gradually.
        if (zero_cnt > lim && zero_cnt > 0)
        begin
            popped = zero_pos[zero_head];
            zero_head = (zero_head + 1) % lkf_pkg::RING_DEPTH;
            zero_cnt--;
            if (popped + 1 > win_left)
                win_left = popped + 1;
        end
        win = (idx + 1 >= win_left) ? idx + 1 - win_left : 0;
        if (win > lkf_pkg::MAX_LEN)
            win = lkf_pkg::MAX_LEN;
        if (win > LEN_CAP)
            win = LEN_CAP;
        if (win > best_run)
            best_run = win;
        r.window_len = win[lkf_pkg::LEN_W-1:0];
        r.best_len   = best_run[lkf_pkg::LEN_W-1:0];
        r.done_res   = last;
        r.overflow   = seq_ovf;
        if (last)
            clear_window();
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        err_count++;
        $display("MISMATCH result %0d: %s", results_seen, msg);
    endtask

    task automatic add_item(logic b, logic last);
        dir_row_t row;
        row = '{kind: ROW_ITEM, limit: '0, bit_value: b, is_last: last, typed: 1'b0,
                want: '0};
        dir_rows.push_back(row);
    endtask

    task automatic add_typed(logic b, logic last, int unsigned win, int unsigned best,
                             logic done, logic ovf);
        dir_row_t row;
        row = '{kind: ROW_ITEM, limit: '0, bit_value: b, is_last: last, typed: 1'b1,
                want: '0};
        row.want.window_len = win[lkf_pkg::LEN_W-1:0];
        row.want.best_len   = best[lkf_pkg::LEN_W-1:0];
        row.want.done_res   = done;
        row.want.overflow   = ovf;
        dir_rows.push_back(row);
    endtask

    task automatic add_cfg(logic [lkf_pkg::LIMIT_W-1:0] v);
        dir_row_t row;
        row = '{kind: ROW_CFG, limit: v, bit_value: 1'b0, is_last: 1'b0, typed: 1'b0,
                want: '0};
        dir_rows.push_back(row);
    endtask

    task automatic send_bit(logic b, logic last, bit typed, lkf_pkg::result_t want);
        lkf_pkg::item_t   it;
        lkf_pkg::result_t pred;
        int               gap;
        gap = tx_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        it.bit_value = b;
        it.is_last   = last;
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        pred = advance_window(b, last);
        expected_results.push_back(typed ? want : pred);
        items_sent++;
    endtask

    // Stops offering bits and waits until every result has come back.
    task automatic drain_results();
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_limit(logic [lkf_pkg::LIMIT_W-1:0] v);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we  <= 1'b0;
        limit_q = v;
    endtask

    task automatic send_random_run(int len, int ones_pct, bit close);
        logic b;
        for (int i = 0; i < len; i++)
        begin
            b = ($urandom_range(0, 99) < ones_pct);
            send_bit(b, close && (i == len - 1), 1'b0, '0);
        end
    endtask

    // Result side: random stalls per transfer, plus long hold-offs on request.
    initial
    begin
        int               n;
        lkf_pkg::result_t want;
        res_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (long_holds > 0)
            begin
                long_holds--;
                n = LONG_HOLD;
            end
            else
                n = rx_idle ? $urandom_range(0, 12) : 0;
            if (n > 0)
            begin
                res_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            res_stall <= 1'b0;
            do
                @(posedge clk);
            while (!res_valid);
            if (expected_results.size() == 0)
                report_mismatch("result transfer with nothing expected");
            else
            begin
                want = expected_results.pop_front();
                if (res.window_len !== want.window_len)
                    report_mismatch($sformatf("window_len got %0d expected %0d",
                                              res.window_len, want.window_len));
                if (res.best_len !== want.best_len)
                    report_mismatch($sformatf("best_len got %0d expected %0d",
                                              res.best_len, want.best_len));
                if (res.done_res !== want.done_res)
                    report_mismatch($sformatf("done_res got %b expected %b",
                                              res.done_res, want.done_res));
                if (res.overflow !== want.overflow)
                    report_mismatch($sformatf("overflow got %b expected %b",
                                              res.overflow, want.overflow));
            end
            results_seen++;
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("longest_ones_with_k_flips_test: errors");
        $finish;
    end

    initial
    begin
        int                          rand_start;
        int                          runs;
        int                          len;
        int                          remaining;
        logic [lkf_pkg::LIMIT_W-1:0] lim;
        clk        = 1'b0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_data   = '0;
        item_valid = 1'b0;
        item       = '0;
        tx_idle    = 1'b1;
        rx_idle    = 1'b1;
        long_holds = 0;
        err_count  = 0;
        items_sent = 0;
        results_seen = 0;
        limit_q    = '0;
        clear_window();

        // Fresh out of reset the limit is zero, so every zero is dropped at once.
        add_typed(1'b1, 1'b0, 1, 1, 1'b0, 1'b0);
        add_typed(1'b0, 1'b0, 0, 1, 1'b0, 1'b0);
        add_typed(1'b1, 1'b1, 1, 1, 1'b1, 1'b0);
        add_typed(1'b0, 1'b1, 0, 0, 1'b1, 1'b0);
        // Largest limit: every zero counts as a one.
        add_cfg(8'd255);
        add_typed(1'b0, 1'b0, 1, 1, 1'b0, 1'b0);
        add_typed(1'b0, 1'b0, 2, 2, 1'b0, 1'b0);
        add_typed(1'b1, 1'b0, 3, 3, 1'b0, 1'b0);
        add_typed(1'b0, 1'b1, 4, 4, 1'b1, 1'b0);
        add_cfg(8'd1);
        add_item(1'b1, 1'b0);
        add_item(1'b0, 1'b0);
        add_item(1'b1, 1'b0);
        add_item(1'b1, 1'b0);
        add_item(1'b0, 1'b0);
        add_item(1'b1, 1'b0);
        add_item(1'b0, 1'b1);
        // Open a sequence, then lower the limit while it is still running.
        add_cfg(8'd3);
        add_item(1'b0, 1'b0);
        add_item(1'b0, 1'b0);
        add_item(1'b0, 1'b0);
        add_item(1'b1, 1'b0);
        add_cfg(8'd0);
        add_item(1'b1, 1'b0);
        add_item(1'b1, 1'b0);
        add_item(1'b1, 1'b1);
        add_cfg(8'd128);
        add_item(1'b1, 1'b1);
        add_item(1'b0, 1'b1);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_limit(dir_rows[i].limit);
            else
                send_bit(dir_rows[i].bit_value, dir_rows[i].is_last, dir_rows[i].typed,
                         dir_rows[i].want);
        end

        // Receiver holds off while the sender keeps offering bits back to back.
        write_limit(8'd4);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        long_holds = 2;
        send_random_run(30, 60, 1'b1);

        rand_start = items_sent;
        while (items_sent - rand_start < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 4))
                0: lim = 8'd0;
                1: lim = 8'd255;
                2: lim = lkf_pkg::LIMIT_W'($urandom_range(0, 3));
                3: lim = lkf_pkg::LIMIT_W'($urandom_range(0, 12));
                default: lim = lkf_pkg::LIMIT_W'($urandom_range(0, 255));
            endcase
            write_limit(lim);
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            runs = $urandom_range(1, 4);
            for (int r = 0; r < runs; r++)
            begin
                len = ($urandom_range(0, 14) == 0) ? $urandom_range(100, 600)
                                                   : $urandom_range(1, 40);
                remaining = RANDOM_ITEMS - (items_sent - rand_start);
                if (len > remaining)
                    len = remaining;
                // The last run of a phase is sometimes left open for the next limit.
                send_random_run(len, $urandom_range(0, 100),
                                (r < runs - 1) || ($urandom_range(0, 4) != 0));
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (err_count == 0 && expected_results.size() == 0)
            $display("longest_ones_with_k_flips_test: clean");
        else
            $display("longest_ones_with_k_flips_test: errors");
        $finish;
    end

endmodule

`default_nettype wire
